// File: sv/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same check on the usual clk_i and rst_ni
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_CLKD(label, clk_i, rst_ni, prop, msg)

`endif

// File: sv/bdh_pkg.sv
// types and constants of the button debounce and hold timer
package bdh_pkg;

  localparam int unsigned BounceW = 8;
  localparam int unsigned HoldW   = 16;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned IterW   = 4;

  localparam logic [AddrW-1:0] ADDR_BOUNCE  = 3'd0;
  localparam logic [AddrW-1:0] ADDR_DIVISOR = 3'd4;

  localparam logic [BounceW-1:0] BOUNCE_RESET  = 8'd40;
  localparam logic [HoldW-1:0]   DIVISOR_RESET = 16'd100;
  localparam logic [HoldW-1:0]   HOLD_MAX      = 16'hFFFF;
  localparam logic [IterW-1:0]   LAST_ITER     = 4'(HoldW - 1);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PRESSQ  = 3'd1,
    PH_PRESSED = 3'd2,
    PH_RELQ    = 3'd3,
    PH_HOLD    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    SEQ_IDLE  = 2'd0,
    SEQ_START = 2'd1,
    SEQ_DIV   = 2'd2,
    SEQ_DONE  = 2'd3
  } seq_e;

  typedef struct packed {
    logic             level;
    logic             level_changed;
    logic [HoldW-1:0] held_ticks;
  } deb_status_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: sv/bdh_debounce.sv
// five-phase debounce machine with held tick counter
module bdh_debounce (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          pin_i,
  input  logic [bdh_pkg::BounceW-1:0]   bounce_ticks_i,
  output bdh_pkg::deb_status_t          status_o
);
  import bdh_pkg::*;

  phase_e             phase_q, phase_d;
  logic [BounceW-1:0] count_q, count_d;
  logic [HoldW-1:0]   held_q, held_d;
  logic               level_q, level_d;
  logic               lchg_q, lchg_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
      held_q  <= '0;
      level_q <= 1'b0;
      lchg_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      held_q  <= held_d;
      level_q <= level_d;
      lchg_q  <= lchg_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    held_d  = held_q;
    level_d = level_q;
    case (phase_q)
      PH_PRESSQ: begin
        if (pin_i) begin
          if (count_q == '0) phase_d = PH_PRESSED;
          count_d = count_q - 1'b1;
        end else begin
          phase_d = PH_IDLE;
        end
        level_d = 1'b0;
      end
      PH_PRESSED: begin
        if (!pin_i) begin
          count_d = bounce_ticks_i;
          phase_d = PH_RELQ;
        end else begin
          held_d  = '0;
          phase_d = PH_HOLD;
        end
        level_d = 1'b1;
      end
      PH_HOLD: begin
        if (pin_i) begin
          if (held_q != HOLD_MAX) held_d = held_q + 1'b1;
        end else begin
          held_d  = '0;
          phase_d = PH_PRESSED;
        end
      end
      PH_RELQ: begin
        if (!pin_i) begin
          if (count_q == '0) phase_d = PH_IDLE;
          count_d = count_q - 1'b1;
        end else begin
          phase_d = PH_PRESSED;
        end
        level_d = 1'b1;
      end
      default: begin
        phase_d = PH_IDLE;
        if (pin_i) begin
          phase_d = PH_PRESSQ;
          count_d = bounce_ticks_i;
        end
        level_d = 1'b0;
      end
    endcase
    // reported level always tracks the debounced level after a step
    lchg_d = (level_d != level_q);
  end

  assign status_o.level         = level_q;
  assign status_o.level_changed = lchg_q;
  assign status_o.held_ticks    = held_q;

endmodule

// File: sv/bdh_div.sv
// restoring serial divider, one quotient bit per cycle
module bdh_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bdh_pkg::HoldW-1:0]   dividend_i,
  input  logic [bdh_pkg::HoldW-1:0]   divisor_i,
  output bdh_pkg::div_status_t        status_o,
  output logic [bdh_pkg::HoldW-1:0]   quotient_o
);
  import bdh_pkg::*;

  logic             busy_q, busy_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic [HoldW-1:0] rem_q, rem_d;
  logic [HoldW-1:0] quo_q, quo_d;
  logic [HoldW-1:0] dsr_q, dsr_d;
  logic [HoldW:0]   trial;
  logic [HoldW+1:0] diff;
  logic             last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  always_comb begin
    trial  = {rem_q, quo_q[HoldW-1]};
    diff   = {1'b0, trial} - {2'b00, dsr_q};
    last   = busy_q && (iter_q == LAST_ITER);
    busy_d = busy_q;
    iter_d = iter_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // no borrow: the remainder fits below the divisor again
      if (!diff[HoldW+1]) begin
        rem_d = diff[HoldW-1:0];
        quo_d = {quo_q[HoldW-2:0], 1'b1};
      end else begin
        rem_d = trial[HoldW-1:0];
        quo_d = {quo_q[HoldW-2:0], 1'b0};
      end
      iter_d = iter_q + 1'b1;
      if (last) busy_d = 1'b0;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = last;
  assign quotient_o    = quo_q;

endmodule

// File: sv/button_debounce_hold_timer.sv
// top level of the button debounce and hold timer
// One item is one millisecond sample of the button pin; each item gives exactly one result
// with the debounced level, a level change flag, the held tick count divided by hold_divisor
// and a flag when that quotient changes. An item passes through the accepting cycle,
// in which the debounce machine updates, a step to load the divider, the restoring divider
// that produces one quotient bit per cycle, and a step to load the output register, so
// in_ready_o rises again at the edge that loads the result. The output register lets a
// new item be accepted while the previous result still waits; if that result is still
// not taken when the next quotient is ready, the sequencer holds until it is. A zero
// hold_divisor gives a hold step of 65535. Registers sit on an APB-style port:
// bounce_ticks at byte 0, hold_divisor at byte 4; pready is always high and writes
// take effect at the next item.
`include "assert_macros.svh"

module button_debounce_hold_timer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        pin_level_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        level_o,
  output logic                        level_changed_o,
  output logic [bdh_pkg::HoldW-1:0]   hold_step_o,
  output logic                        hold_changed_o,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bdh_pkg::AddrW-1:0]   paddr,
  input  logic [bdh_pkg::DataW-1:0]   pwdata,
  output logic [bdh_pkg::DataW-1:0]   prdata,
  output logic                        pready
);
  import bdh_pkg::*;

  // configuration registers
  logic [BounceW-1:0] bounce_q;
  logic [HoldW-1:0]   divisor_q;
  logic               cfg_wr;

  // sequencer and result registers
  seq_e               seq_q, seq_d;
  logic               accept;
  logic               div_start;
  logic               load_out;
  logic               out_valid_q, out_valid_d;
  logic               level_q;
  logic               lchg_q;
  logic [HoldW-1:0]   step_q;
  logic               hchg_q;
  logic [HoldW-1:0]   rep_step_q;

  deb_status_t        deb_status;
  div_status_t        div_status;
  logic [HoldW-1:0]   quotient;

  // apb write decode, unused addresses are ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounce_q  <= BOUNCE_RESET;
      divisor_q <= DIVISOR_RESET;
    end else if (cfg_wr) begin
      if (paddr == ADDR_BOUNCE)  bounce_q  <= pwdata[BounceW-1:0];
      if (paddr == ADDR_DIVISOR) divisor_q <= pwdata[HoldW-1:0];
    end
  end

  always_comb begin
    case (paddr)
      ADDR_BOUNCE:  prdata = {{(DataW-BounceW){1'b0}}, bounce_q};
      ADDR_DIVISOR: prdata = {{(DataW-HoldW){1'b0}}, divisor_q};
      default:      prdata = '0;
    endcase
  end

  // debounce machine advances once per accepted item
  bdh_debounce u_debounce (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (accept),
    .pin_i          (pin_level_i),
    .bounce_ticks_i (bounce_q),
    .status_o       (deb_status)
  );

  // serial divider for the hold step
  bdh_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (deb_status.held_ticks),
    .divisor_i  (divisor_q),
    .status_o   (div_status),
    .quotient_o (quotient)
  );

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SEQ_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and handshake
  always_comb begin
    seq_d      = seq_q;
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (seq_q)
      SEQ_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) seq_d = SEQ_START;
      end
      SEQ_START: begin
        div_start = 1'b1;
        seq_d     = SEQ_DIV;
      end
      SEQ_DIV: begin
        if (div_status.done) seq_d = SEQ_DONE;
      end
      SEQ_DONE: begin
        // wait for the previous result to leave the output register
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          seq_d    = SEQ_IDLE;
        end
      end
      default: begin
        seq_d = SEQ_IDLE;
      end
    endcase
    accept      = in_valid_i && in_ready_o;
    out_valid_d = load_out || (out_valid_q && !out_ready_i);
  end

  // reported hold step, compared against each new quotient
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_step_q <= '0;
    end else if (load_out) begin
      rep_step_q <= quotient;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      level_q <= deb_status.level;
      lchg_q  <= deb_status.level_changed;
      step_q  <= quotient;
      hchg_q  <= (quotient != rep_step_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign level_o         = level_q;
  assign level_changed_o = lchg_q;
  assign hold_step_o     = step_q;
  assign hold_changed_o  = hchg_q;

  // no item is taken while the divider is working
  `ASSERT_STD(a_ready_div_idle, in_ready_o |-> !div_status.busy, "ready while divider busy")
  // the divider only finishes while the sequencer waits for it
  `ASSERT_STD(a_done_in_div, div_status.done |-> (seq_q == SEQ_DIV), "divider done out of step")
  // an accepted item always starts the divider in the following cycle
  `ASSERT_STD(a_accept_starts, accept |=> div_start, "accepted item did not start divider")
  // a result is only loaded when the output register is free or being emptied
  `ASSERT_STD(a_load_free, load_out |-> (!out_valid_q || out_ready_i), "result overwritten")

endmodule
